// File: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared types, codes and a helper function for the allocator controller,
// datapath and checker.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Order values carry up to the rounded request order and the empty mark.
  localparam int unsigned ORDER_W    = 5;
  localparam logic [ORDER_W-1:0] ORDER_NONE = '1;
  localparam int unsigned PAGE_SHIFT = 12;

  // Opcodes of a request word.
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADPTR  = 2'd2;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_INC_LVL,
    OP_POP_RD,
    OP_POP_WR,
    OP_SPLIT,
    OP_PUSH1,
    OP_PUSH2,
    OP_RECORD,
    OP_F_RD,
    OP_F_ORD,
    OP_M_RD,
    OP_M_UNLINK,
    OP_FINISH
  } bpa_op_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHECK,
    S_SEARCH,
    S_POP_RD,
    S_POP_WR,
    S_PUSH1,
    S_PUSH2,
    S_RECORD,
    S_F_CHECK,
    S_F_ORD,
    S_M_RD,
    S_M_CHK,
    S_FIN
  } bpa_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    bpa_op_t    op;
    logic       accept;
    logic       set_status;
    logic [1:0] status_val;
  } bpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic too_big;
    logic head_nz;
    logic lvl_top;
    logic lvl_gt_ord;
    logic pnode_odd;
    logic bad_page;
    logic bad_order;
    logic node_root;
    logic buddy_on;
    logic out_free;
  } bpa_sts_t;

  // Number of significant bits of a 20-bit value.
  function automatic logic [ORDER_W-1:0] bit_len(input logic [19:0] v);
    logic [ORDER_W-1:0] len;
    len = '0;
    for (int i = 0; i < 20; i++) begin
      if (v[i]) begin
        len = ORDER_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

// File: rtl/bpa_if.sv
// ----------------------------------------------------------------------------
// Buddy page allocator channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] request_bytes;
  logic [31:0] free_address;

  modport source (output valid, opcode, request_bytes, free_address, input ready);
  modport sink   (input valid, opcode, request_bytes, free_address, output ready);
endinterface

interface bpa_resp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;

  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

interface bpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences the clearing pass, the free list search, splits, merges and
// result hand-off by issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  import bpa_pkg::*;

  bpa_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command.
  always_comb begin
    state_next     = state;
    cmd.op         = OP_IDLE;
    cmd.accept     = 1'b0;
    cmd.set_status = 1'b0;
    cmd.status_val = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_A_CHECK;
        end
      end
      S_A_CHECK: begin
        // The accepted word is latched now; branch on its opcode and, for an allocate, on its order.
        if (sts.is_free) begin
          state_next = S_F_CHECK;
        end else if (sts.too_big) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.head_nz) begin
          state_next = S_POP_RD;
        end else if (sts.lvl_top) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_NOSPACE;
          state_next     = S_FIN;
        end else begin
          cmd.op = OP_INC_LVL;
        end
      end
      S_POP_RD: begin
        cmd.op     = OP_POP_RD;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        if (sts.lvl_gt_ord) begin
          cmd.op     = OP_SPLIT;
          state_next = S_PUSH1;
        end else begin
          cmd.op     = OP_POP_WR;
          state_next = S_RECORD;
        end
      end
      S_PUSH1: begin
        cmd.op     = OP_PUSH1;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.op = OP_PUSH2;
        if (sts.is_free) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_OK;
          state_next     = S_FIN;
        end else if (sts.pnode_odd) begin
          state_next = S_SEARCH;
        end else begin
          state_next = S_PUSH1;
        end
      end
      S_RECORD: begin
        cmd.op     = OP_RECORD;
        state_next = S_FIN;
      end
      S_F_CHECK: begin
        if (sts.bad_page) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_BADPTR;
          state_next     = S_FIN;
        end else begin
          cmd.op     = OP_F_RD;
          state_next = S_F_ORD;
        end
      end
      S_F_ORD: begin
        if (sts.bad_order) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_BADPTR;
          state_next     = S_FIN;
        end else begin
          cmd.op     = OP_F_ORD;
          state_next = S_M_RD;
        end
      end
      S_M_RD: begin
        if (sts.node_root) begin
          state_next = S_PUSH1;
        end else begin
          cmd.op     = OP_M_RD;
          state_next = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if (sts.buddy_on) begin
          cmd.op     = OP_M_UNLINK;
          state_next = S_M_RD;
        end else begin
          state_next = S_PUSH1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Holds the free list heads, link, membership and order memories, the
// working registers and the response register.
// ----------------------------------------------------------------------------
module bpa_dp #(
  parameter int unsigned POOL_PAGES = 1024,
  parameter int unsigned TOP_ORDER  = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::bpa_cmd_t cmd,
  output bpa_pkg::bpa_sts_t sts,
  input  logic              cfg_write,
  input  logic [31:0]       cfg_data,
  input  logic              req_opcode,
  input  logic [31:0]       req_bytes,
  input  logic [31:0]       req_addr,
  output logic              resp_valid,
  input  logic              resp_ready,
  output logic [31:0]       resp_addr,
  output logic [1:0]        resp_status
);
  import bpa_pkg::*;

  localparam int unsigned NODE_W     = TOP_ORDER + 1;
  localparam int unsigned NODE_COUNT = 2 ** NODE_W;
  localparam int unsigned PAGE_W     = $clog2(POOL_PAGES);
  localparam int unsigned HEAD_W     = $clog2(TOP_ORDER + 1);
  localparam int unsigned CLR_N      = (NODE_COUNT > POOL_PAGES) ? NODE_COUNT : POOL_PAGES;
  localparam int unsigned CLR_W      = $clog2(CLR_N);

  // Memories.
  logic [NODE_W-1:0]  nxt_mem [NODE_COUNT];
  logic [NODE_W-1:0]  prv_mem [NODE_COUNT];
  logic               on_mem  [NODE_COUNT];
  logic [ORDER_W-1:0] pbo_mem [POOL_PAGES];

  logic [NODE_W-1:0]  nxt_rd, prv_rd;
  logic               on_rd;
  logic [ORDER_W-1:0] pbo_rd;

  // Free list heads, one per order.
  logic [NODE_W-1:0] head [TOP_ORDER + 1];

  // Working registers.
  logic [31:0]        pool_base;
  logic               opcode;
  logic [ORDER_W-1:0] ord;
  logic [ORDER_W-1:0] lvl;
  logic [19:0]        page;
  logic [NODE_W-1:0]  pop_node;
  logic [NODE_W-1:0]  pnode;
  logic [NODE_W-1:0]  hsave;
  logic [31:0]        res_addr;
  logic [1:0]         res_status;
  logic [CLR_W-1:0]   clr_cnt;

  // Memory port controls.
  logic               nxt_we, prv_we, on_we, pbo_we;
  logic [NODE_W-1:0]  nxt_wa, prv_wa, on_wa;
  logic [NODE_W-1:0]  nxt_wd, prv_wd;
  logic               on_wd;
  logic [PAGE_W-1:0]  pbo_wa;
  logic [ORDER_W-1:0] pbo_wd;
  logic               nxt_re, lnk_re, pbo_re;
  logic [NODE_W-1:0]  nxt_ra;

  logic [HEAD_W-1:0]  hidx;
  logic [NODE_W-1:0]  head_cur;
  logic [NODE_W-1:0]  buddy;
  logic [19:0]        req_pages_m1;
  logic [31:0]        byte_m1;
  logic [31:0]        offset;
  logic [31:0]        blk_idx;
  logic [31:0]        start_pg;
  logic [31:0]        free_node;

  assign hidx     = lvl[HEAD_W-1:0];
  assign head_cur = head[hidx];
  assign buddy    = pnode ^ NODE_W'(1);

  // Request decode: pages minus one, and the byte offset of a free from the pool base.
  assign byte_m1      = req_bytes - 32'd1;
  assign req_pages_m1 = (req_bytes == 32'd0) ? 20'd0 : byte_m1[31:PAGE_SHIFT];
  assign offset       = req_addr - pool_base;

  // Block start page of the popped node, and the tree node of a freed page.
  assign blk_idx   = 32'(pop_node) - (32'd1 << (32'(TOP_ORDER) - 32'(ord)));
  assign start_pg  = blk_idx << ord;
  assign free_node = (32'd1 << (32'(TOP_ORDER) - 32'(pbo_rd))) + (32'(page) >> pbo_rd);

  // Memory port selection per operation.
  always_comb begin
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    on_we  = 1'b0; on_wa  = '0; on_wd  = 1'b0;
    pbo_we = 1'b0; pbo_wa = '0; pbo_wd = ORDER_NONE;
    nxt_re = 1'b0; nxt_ra = '0;
    lnk_re = 1'b0; pbo_re = 1'b0;
    unique case (cmd.op)
      OP_CLEAR: begin
        nxt_we = (32'(clr_cnt) < NODE_COUNT);
        nxt_wa = clr_cnt[NODE_W-1:0];
        prv_we = (32'(clr_cnt) < NODE_COUNT);
        prv_wa = clr_cnt[NODE_W-1:0];
        on_we  = (32'(clr_cnt) < NODE_COUNT);
        on_wa  = clr_cnt[NODE_W-1:0];
        on_wd  = (32'(clr_cnt) == 32'd1);
        pbo_we = (32'(clr_cnt) < POOL_PAGES);
        pbo_wa = clr_cnt[PAGE_W-1:0];
      end
      OP_POP_RD: begin
        nxt_re = 1'b1;
        nxt_ra = head_cur;
        on_we  = 1'b1;
        on_wa  = head_cur;
      end
      OP_POP_WR, OP_SPLIT: begin
        prv_we = (nxt_rd != '0);
        prv_wa = nxt_rd;
      end
      OP_PUSH1: begin
        nxt_we = 1'b1; nxt_wa = pnode; nxt_wd = head_cur;
        prv_we = 1'b1; prv_wa = pnode;
        on_we  = 1'b1; on_wa  = pnode; on_wd = 1'b1;
      end
      OP_PUSH2: begin
        prv_we = (hsave != '0);
        prv_wa = hsave;
        prv_wd = pnode;
      end
      OP_RECORD: begin
        pbo_we = (start_pg < 32'(POOL_PAGES));
        pbo_wa = start_pg[PAGE_W-1:0];
        pbo_wd = ord;
      end
      OP_F_RD: begin
        pbo_re = 1'b1;
      end
      OP_F_ORD: begin
        pbo_we = 1'b1;
        pbo_wa = page[PAGE_W-1:0];
      end
      OP_M_RD: begin
        nxt_re = 1'b1;
        nxt_ra = buddy;
        lnk_re = 1'b1;
      end
      OP_M_UNLINK: begin
        on_we  = 1'b1; on_wa = buddy;
        nxt_we = (prv_rd != '0); nxt_wa = prv_rd; nxt_wd = nxt_rd;
        prv_we = (nxt_rd != '0); prv_wa = nxt_rd; prv_wd = prv_rd;
      end
      default: begin
      end
    endcase
  end

  // Link memories.
  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (nxt_re) begin
      nxt_rd <= nxt_mem[nxt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (lnk_re) begin
      prv_rd <= prv_mem[buddy];
    end
  end

  // Free list membership memory.
  always_ff @(posedge clk) begin
    if (on_we) begin
      on_mem[on_wa] <= on_wd;
    end
    if (lnk_re) begin
      on_rd <= on_mem[buddy];
    end
  end

  // Block order per start page.
  always_ff @(posedge clk) begin
    if (pbo_we) begin
      pbo_mem[pbo_wa] <= pbo_wd;
    end
    if (pbo_re) begin
      pbo_rd <= pbo_mem[page[PAGE_W-1:0]];
    end
  end

  // Free list heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= TOP_ORDER; i++) begin
        head[i] <= (i == TOP_ORDER) ? NODE_W'(1) : '0;
      end
    end else begin
      unique case (cmd.op)
        OP_POP_WR, OP_SPLIT: head[hidx] <= nxt_rd;
        OP_PUSH2:            head[hidx] <= pnode;
        OP_M_UNLINK: begin
          if (prv_rd == '0) begin
            head[hidx] <= nxt_rd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers: pool base, clear counter, response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      clr_cnt    <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        pool_base <= cfg_data;
      end
      if (cmd.op == OP_CLEAR && !sts.clr_last) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (cmd.op == OP_FINISH) begin
        resp_valid <= 1'b1;
      end else if (resp_ready) begin
        resp_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        opcode     <= req_opcode;
        ord        <= bit_len(req_pages_m1);
        lvl        <= bit_len(req_pages_m1);
        page       <= offset[31:PAGE_SHIFT];
        res_addr   <= '0;
        res_status <= ST_NOSPACE;
      end
      OP_INC_LVL:  lvl <= lvl + ORDER_W'(1);
      OP_POP_RD:   pop_node <= head_cur;
      OP_SPLIT: begin
        lvl   <= lvl - ORDER_W'(1);
        pnode <= {pop_node[NODE_W-2:0], 1'b0};
      end
      OP_PUSH1:    hsave <= head_cur;
      OP_PUSH2:    pnode <= pnode | NODE_W'(1);
      OP_RECORD: begin
        res_addr   <= pool_base + (start_pg << PAGE_SHIFT);
        res_status <= ST_OK;
      end
      OP_F_ORD: begin
        lvl   <= pbo_rd;
        pnode <= free_node[NODE_W-1:0];
      end
      OP_M_UNLINK: begin
        lvl   <= lvl + ORDER_W'(1);
        pnode <= pnode >> 1;
      end
      OP_FINISH: begin
        resp_addr   <= res_addr;
        resp_status <= res_status;
      end
      default: begin
      end
    endcase
    if (cmd.set_status) begin
      res_status <= cmd.status_val;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.clr_last   = (32'(clr_cnt) == CLR_N - 1);
    sts.is_free    = (opcode == OPC_FREE);
    sts.too_big    = (32'(ord) > TOP_ORDER);
    sts.head_nz    = (head_cur != '0);
    sts.lvl_top    = (32'(lvl) == TOP_ORDER);
    sts.lvl_gt_ord = (lvl > ord);
    sts.pnode_odd  = pnode[0];
    sts.bad_page   = (32'(page) >= POOL_PAGES);
    sts.bad_order  = (32'(pbo_rd) > TOP_ORDER);
    sts.node_root  = (pnode <= NODE_W'(1));
    sts.buddy_on   = on_rd;
    sts.out_free   = !resp_valid || resp_ready;
  end

endmodule

// File: rtl/buddy_page_allocator.sv
// Requests are taken one at a time: a new word is not accepted until the result
// of the previous one has been moved into the response register.
// Reset: synchronous; afterwards a clearing pass over max(2^(TOP_ORDER+1), POOL_PAGES)
// entries (2048 at defaults) resets links, membership and page orders before the
// first request is taken. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks from a pool of 4 KiB pages.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int unsigned POOL_PAGES = 1024,
  parameter int unsigned TOP_ORDER  = 10
) (
  input logic       clk,
  input logic       rst,
  bpa_req_if.sink   req,
  bpa_resp_if.source resp,
  bpa_cfg_if.sink   cfg
);
  import bpa_pkg::*;

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  assign req.ready = cmd.accept;
  assign cfg.ready = 1'b1;

  // Sequencer.
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Lists, memories and result register.
  bpa_dp #(
    .POOL_PAGES (POOL_PAGES),
    .TOP_ORDER  (TOP_ORDER)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_write   (cfg.valid),
    .cfg_data    (cfg.data),
    .req_opcode  (req.opcode),
    .req_bytes   (req.request_bytes),
    .req_addr    (req.free_address),
    .resp_valid  (resp.valid),
    .resp_ready  (resp.ready),
    .resp_addr   (resp.block_address),
    .resp_status (resp.status)
  );

endmodule

// File: rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// Buddy page allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        resp_valid,
  input logic        resp_ready,
  input logic [31:0] block_address,
  input logic [1:0]  status
);
  import bpa_pkg::*;

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> (status == ST_OK || status == ST_NOSPACE || status == ST_BADPTR))
    else $error("undefined status code");

  // A failed word carries a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && status != ST_OK) |-> (block_address == 32'd0))
    else $error("nonzero address on failure");

  // One request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // A stalled response holds.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && !resp_ready) |=>
      (resp_valid && $stable(block_address) && $stable(status)))
    else $error("response changed while stalled");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .resp_valid    (resp.valid),
  .resp_ready    (resp.ready),
  .block_address (resp.block_address),
  .status        (resp.status)
);
